[sv/mrq_pkg.sv]
package mrq_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int MAX_DEPTH    = 256;
  localparam int NUM_REGS     = 4;

  localparam int CAP_W     = 9;
  localparam int CH_IN_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W     = 8;
  localparam int WORD_W    = 32;

  localparam int CH_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PTR_W    = $clog2(MAX_DEPTH);
  localparam int SLOTS    = NUM_CHANNELS * MAX_DEPTH;
  localparam int ADDR_W   = $clog2(SLOTS);

  // largest capacity that still fits the per-channel region
  localparam logic [CAP_W-1:0] DEPTH_CAP =
      (MAX_DEPTH > (2**CAP_W - 1)) ? {CAP_W{1'b1}} : CAP_W'(MAX_DEPTH);

  localparam logic [WORD_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_CHANNEL = 3'd1,
    ST_CLOSED      = 3'd2,
    ST_FULL        = 3'd3,
    ST_EMPTY       = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [CH_IN_W-1:0] channel;
    logic [WORD_W-1:0]  frame_index_in;
    logic [WORD_W-1:0]  decode_stamp_in;
    logic [WORD_W-1:0]  present_stamp_in;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] frame_index_out;
    logic [WORD_W-1:0] decode_stamp_out;
    logic [WORD_W-1:0] present_stamp_out;
    logic [CNT_W-1:0]  active_count;
    logic [CNT_W-1:0]  free_count;
  } out_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] frame;
    logic [WORD_W-1:0] dts;
    logic [WORD_W-1:0] pts;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [CFG_IDX_W-1:0] index;
    logic [CAP_W-1:0]  data;
  } cfg_wr_t;

  typedef struct packed {
    logic              wr;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } mem_req_t;

  typedef struct packed {
    status_t          status;
    logic             hit;
    logic [CNT_W-1:0] active;
    logic [CNT_W-1:0] free_cnt;
  } ctrl_res_t;

endpackage

[sv/mrq_store.sv]
module mrq_store (
  input  logic               clk,
  input  mrq_pkg::mem_req_t  req,
  output mrq_pkg::entry_t    rdata
);

  mrq_pkg::entry_t mem [mrq_pkg::SLOTS];

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= req.data;
    end
    rdata <= mem[req.addr];
  end

endmodule

[sv/mrq_ctrl.sv]
module mrq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  mrq_pkg::in_item_t   cmd,
  input  mrq_pkg::cfg_wr_t    cfg,
  output mrq_pkg::mem_req_t   mem_req,
  output mrq_pkg::ctrl_res_t  res
);

  localparam int CAP_W = mrq_pkg::CAP_W;
  localparam int PTR_W = mrq_pkg::PTR_W;
  localparam int CH_W  = mrq_pkg::CH_W;

  logic [CAP_W-1:0] capacity      [mrq_pkg::NUM_CHANNELS];
  logic [PTR_W-1:0] write_pointer [mrq_pkg::NUM_CHANNELS];
  logic [PTR_W-1:0] read_pointer  [mrq_pkg::NUM_CHANNELS];

  logic [CH_W-1:0]  chi;
  logic             bad;
  logic [CAP_W-1:0] cap_raw, cap;
  logic [CAP_W-1:0] w, r, wn, rn, w_a, r_a;
  logic [CAP_W-1:0] active, freec;
  logic             adv_w, adv_r;
  mrq_pkg::status_t status;
  logic             hit;

  always_comb begin
    chi     = CH_W'(cmd.channel);
    bad     = (32'(cmd.channel) >= mrq_pkg::NUM_CHANNELS);
    cap_raw = capacity[chi];
    cap     = (cap_raw > mrq_pkg::DEPTH_CAP) ? mrq_pkg::DEPTH_CAP : cap_raw;
    w       = CAP_W'(write_pointer[chi]);
    r       = CAP_W'(read_pointer[chi]);
    // pointers always stay below the capacity, so wrap is a single compare
    wn      = (w + CAP_W'(1) == cap) ? '0 : w + CAP_W'(1);
    rn      = (r + CAP_W'(1) == cap) ? '0 : r + CAP_W'(1);

    status = mrq_pkg::ST_OK;
    hit    = 1'b0;
    adv_w  = 1'b0;
    adv_r  = 1'b0;
    w_a    = w;
    r_a    = r;

    if (bad) begin
      status = mrq_pkg::ST_BAD_CHANNEL;
    end else if (cap == '0) begin
      status = mrq_pkg::ST_CLOSED;
    end else if (cmd.operation == mrq_pkg::OP_PUSH) begin
      if (wn == r) begin
        status = mrq_pkg::ST_FULL;
      end else begin
        adv_w = 1'b1;
        w_a   = wn;
      end
    end else begin
      // pop, peek, and the unused code which behaves as peek
      if (w == r) begin
        status = mrq_pkg::ST_EMPTY;
      end else begin
        hit = 1'b1;
        if (cmd.operation == mrq_pkg::OP_POP) begin
          adv_r = 1'b1;
          r_a   = rn;
        end
      end
    end

    active = (w_a >= r_a) ? (w_a - r_a) : (cap - (r_a - w_a));
    freec  = (cap > active + CAP_W'(1)) ? (cap - active - CAP_W'(1)) : '0;
    if (bad || cap == '0) begin
      active = '0;
      freec  = '0;
    end

    res.status   = status;
    res.hit      = hit;
    res.active   = (active > CAP_W'(255)) ? 8'hFF : active[7:0];
    res.free_cnt = (freec > CAP_W'(255)) ? 8'hFF : freec[7:0];

    mem_req.wr   = cmd_valid && adv_w;
    mem_req.addr = mrq_pkg::ADDR_W'(chi) * mrq_pkg::ADDR_W'(mrq_pkg::MAX_DEPTH)
                 + mrq_pkg::ADDR_W'((cmd.operation == mrq_pkg::OP_PUSH) ? w : r);
    mem_req.data.frame = cmd.frame_index_in;
    mem_req.data.dts   = cmd.decode_stamp_in;
    mem_req.data.pts   = cmd.present_stamp_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mrq_pkg::NUM_CHANNELS; i++) begin
        capacity[i]      <= '0;
        write_pointer[i] <= '0;
        read_pointer[i]  <= '0;
      end
    end else begin
      if (cmd_valid && adv_w) begin
        write_pointer[chi] <= PTR_W'(wn);
      end
      if (cmd_valid && adv_r) begin
        read_pointer[chi] <= PTR_W'(rn);
      end
      // capacity write empties the channel
      if (cfg.en && 32'(cfg.index) < mrq_pkg::NUM_REGS
          && 32'(cfg.index) < mrq_pkg::NUM_CHANNELS) begin
        capacity[CH_W'(cfg.index)]      <= cfg.data;
        write_pointer[CH_W'(cfg.index)] <= '0;
        read_pointer[CH_W'(cfg.index)]  <= '0;
      end
    end
  end

endmodule

[sv/multichannel_ring_queue.sv]
// Multichannel ring queue: several circular frame-entry queues in one store.
// Command channel: present command with start high; the item is taken at a
// rising edge with start high and busy low. busy is high only during reset,
// so one item can be taken every cycle.
// Each item is a push, pop or peek on one channel. Exactly one result per
// item appears on result with done high for one cycle. The item is held in
// the input register; pointer update, store read and result register then
// follow at the same edge, and done rises with them.
// Sustained rate is one item per cycle while not in reset, set by the single
// store port used once per item.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data write the
// capacity of a channel and empty it; cfg_ready is always high. Write only
// while no item is in flight.
// Reset clears capacities (all channels closed) and pointers. The entry
// store itself is not cleared; no read can reach an unwritten entry.
// The receiver cannot stall: done is a strobe and each result is gone
// after its one cycle.
module multichannel_ring_queue (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  mrq_pkg::in_item_t                   command,
  output logic                                done,
  output mrq_pkg::out_item_t                  result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mrq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mrq_pkg::CAP_W-1:0]           cfg_data
);

  logic               cmd_valid;
  mrq_pkg::in_item_t  cmd;
  mrq_pkg::cfg_wr_t   cfg;
  mrq_pkg::mem_req_t  mem_req;
  mrq_pkg::ctrl_res_t res;
  mrq_pkg::ctrl_res_t res_q;
  mrq_pkg::entry_t    rdata;

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  assign cfg.en    = cfg_valid && cfg_ready;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      cmd_valid <= start && !busy;
      done      <= cmd_valid;
    end
    if (start && !busy) begin
      cmd <= command;
    end
    res_q <= res;
  end

  mrq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cfg       (cfg),
    .mem_req   (mem_req),
    .res       (res)
  );

  mrq_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  always_comb begin
    result.status            = res_q.status;
    result.frame_index_out   = res_q.hit ? rdata.frame : '0;
    result.decode_stamp_out  = res_q.hit ? rdata.dts : mrq_pkg::ALL_ONES;
    result.present_stamp_out = res_q.hit ? rdata.pts : mrq_pkg::ALL_ONES;
    result.active_count      = res_q.active;
    result.free_count        = res_q.free_cnt;
  end

  a_item_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |=> done)
    else $error("item in flight produced no result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    !cmd_valid |=> !done)
    else $error("result without an item");

  a_error_counts_zero: assert property (@(posedge clk) disable iff (rst)
    done && (result.status == mrq_pkg::ST_BAD_CHANNEL
             || result.status == mrq_pkg::ST_CLOSED)
    |-> result.active_count == '0 && result.free_count == '0)
    else $error("nonzero counts on bad or closed channel");

  a_push_no_entry: assert property (@(posedge clk) disable iff (rst)
    done && $past(cmd.operation == mrq_pkg::OP_PUSH)
    |-> result.frame_index_out == '0 && result.decode_stamp_out == mrq_pkg::ALL_ONES)
    else $error("push returned an entry");

endmodule
